// ===== hw/rtl/biq_pkg.sv =====
// Shared widths, codes and control structures of the biquad IIR section.
// Used by biq_cfg, biq_seq, biq_dp and biquad_iir_filter_top; no dependencies.
package biq_pkg;

  localparam int DATA_W  = 16;
  localparam int COEF_W  = 16;
  localparam int FRAC_W  = COEF_W - 2;
  localparam int PROD_W  = DATA_W + COEF_W;
  localparam int ACC_W   = 64;
  localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W  = 4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GIN  = 3'd5,
    REG_GOUT = 3'd6,
    REG_FORM = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    SA_RAW, SA_X, SA_W, SA_S, SA_X1, SA_X2, SA_Y1, SA_Y2, SA_D1, SA_D2
  } sel_a_t;

  typedef enum logic [2:0] {
    SB_B0, SB_B1, SB_B2, SB_A1, SB_A2, SB_GIN, SB_GOUT, SB_ONE
  } sel_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    DST_X, DST_W, DST_S, DST_OUT
  } fin_dst_t;

  typedef enum logic [1:0] {
    COMMIT_NONE, COMMIT_DF1, COMMIT_DF2
  } commit_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] gin;
    logic signed [COEF_W-1:0] gout;
    logic                     form;
  } cfg_t;

  typedef struct packed {
    sel_a_t   a_sel;
    sel_b_t   b_sel;
    logic     neg;
    acc_op_t  acc_op;
    logic     fin_en;
    fin_dst_t fin_dst;
    commit_t  commit;
    logic     last;
  } ctrl_t;

endpackage

// ===== hw/rtl/biq_cfg.sv =====
// Coefficient, gain and form registers of the biquad section.
// Depends on biq_pkg.
module biq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [biq_pkg::COEF_W-1:0]    cfg_wdata,
  output biq_pkg::cfg_t                 cfg
);
  import biq_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0   <= COEF_ONE;
      cfg_r.b1   <= '0;
      cfg_r.b2   <= '0;
      cfg_r.a1   <= '0;
      cfg_r.a2   <= '0;
      cfg_r.gin  <= COEF_ONE;
      cfg_r.gout <= COEF_ONE;
      cfg_r.form <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_B0:   cfg_r.b0   <= cfg_wdata;
        REG_B1:   cfg_r.b1   <= cfg_wdata;
        REG_B2:   cfg_r.b2   <= cfg_wdata;
        REG_A1:   cfg_r.a1   <= cfg_wdata;
        REG_A2:   cfg_r.a2   <= cfg_wdata;
        REG_GIN:  cfg_r.gin  <= cfg_wdata;
        REG_GOUT: cfg_r.gout <= cfg_wdata;
        REG_FORM: cfg_r.form <= cfg_wdata[0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/biq_seq.sv =====
// Step sequencer: walks the multiply/accumulate program of the selected form.
// Depends on biq_pkg.
module biq_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           form,
  input  logic           out_blocked,
  output logic           busy,
  output biq_pkg::ctrl_t ctrl
);
  import biq_pkg::*;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  ctrl_t             prog;
  logic              advance;

  function automatic ctrl_t ucode(input logic f, input logic [STEP_W-1:0] s);
    ctrl_t c;
    c = '0;
    if (!f) begin
      case (s)
        4'd0:  begin c.a_sel = SA_RAW; c.b_sel = SB_GIN; end
        4'd1:  c.acc_op = ACC_LOAD;
        4'd2:  begin c.fin_en = 1'b1; c.fin_dst = DST_X; end
        4'd3:  begin c.a_sel = SA_X; c.b_sel = SB_B0; end
        4'd4:  begin c.acc_op = ACC_LOAD; c.a_sel = SA_X1; c.b_sel = SB_B1; end
        4'd5:  begin c.acc_op = ACC_ADD; c.a_sel = SA_X2; c.b_sel = SB_B2; end
        4'd6:  begin c.acc_op = ACC_ADD; c.a_sel = SA_Y1; c.b_sel = SB_A1; c.neg = 1'b1; end
        4'd7:  begin c.acc_op = ACC_ADD; c.a_sel = SA_Y2; c.b_sel = SB_A2; c.neg = 1'b1; end
        4'd8:  c.acc_op = ACC_ADD;
        4'd9:  begin c.fin_en = 1'b1; c.fin_dst = DST_S; end
        4'd10: begin c.a_sel = SA_S; c.b_sel = SB_GOUT; end
        4'd11: c.acc_op = ACC_LOAD;
        4'd12: begin
          c.fin_en = 1'b1; c.fin_dst = DST_OUT; c.commit = COMMIT_DF1; c.last = 1'b1;
        end
        default: c.last = 1'b1;
      endcase
    end else begin
      case (s)
        4'd0:  begin c.a_sel = SA_RAW; c.b_sel = SB_GIN; end
        4'd1:  c.acc_op = ACC_LOAD;
        4'd2:  begin c.fin_en = 1'b1; c.fin_dst = DST_X; end
        4'd3:  begin c.a_sel = SA_X; c.b_sel = SB_ONE; end
        4'd4:  begin c.acc_op = ACC_LOAD; c.a_sel = SA_D1; c.b_sel = SB_A1; c.neg = 1'b1; end
        4'd5:  begin c.acc_op = ACC_ADD; c.a_sel = SA_D2; c.b_sel = SB_A2; c.neg = 1'b1; end
        4'd6:  c.acc_op = ACC_ADD;
        4'd7:  begin c.fin_en = 1'b1; c.fin_dst = DST_W; end
        4'd8:  begin c.a_sel = SA_W; c.b_sel = SB_B0; end
        4'd9:  begin c.acc_op = ACC_LOAD; c.a_sel = SA_D1; c.b_sel = SB_B1; end
        4'd10: begin c.acc_op = ACC_ADD; c.a_sel = SA_D2; c.b_sel = SB_B2; end
        4'd11: c.acc_op = ACC_ADD;
        4'd12: begin c.fin_en = 1'b1; c.fin_dst = DST_S; end
        4'd13: begin c.a_sel = SA_S; c.b_sel = SB_GOUT; end
        4'd14: c.acc_op = ACC_LOAD;
        4'd15: begin
          c.fin_en = 1'b1; c.fin_dst = DST_OUT; c.commit = COMMIT_DF2; c.last = 1'b1;
        end
        default: c.last = 1'b1;
      endcase
    end
    return c;
  endfunction

  assign prog    = ucode(form, step_r);
  assign advance = (state_r == ST_RUN) && !(prog.last && out_blocked);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_RUN;
            step_r  <= '0;
          end
        end
        ST_RUN: begin
          if (advance) begin
            if (prog.last) begin
              state_r <= ST_IDLE;
            end
            step_r <= step_r + STEP_W'(1);
          end
        end
      endcase
    end
  end

  assign busy = (state_r == ST_RUN);

  always_comb begin
    ctrl = '0;
    if (advance) begin
      ctrl = prog;
    end
  end

endmodule

// ===== hw/rtl/biq_dp.sv =====
// Datapath: one shared multiplier, saturating accumulator, rounding and filter state.
// Depends on biq_pkg; driven by biq_seq control words.
module biq_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_load,
  input  logic signed [biq_pkg::DATA_W-1:0] in_sample,
  input  biq_pkg::cfg_t                    cfg,
  input  biq_pkg::ctrl_t                   ctrl,
  output logic signed [biq_pkg::DATA_W-1:0] out_word
);
  import biq_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] scale_back(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] sh;
    r  = sat_add(a, ACC_RND);
    sh = r >>> FRAC_W;
    if ((&sh[ACC_W-1:DATA_W-1]) || !(|sh[ACC_W-1:DATA_W-1])) begin
      return sh[DATA_W-1:0];
    end
    return sh[ACC_W-1] ? DATA_MIN : DATA_MAX;
  endfunction

  logic signed [DATA_W-1:0] raw_r, x_r, w_r, s_r;
  logic signed [DATA_W-1:0] x1_r, x2_r, y1_r, y2_r, d1_r, d2_r;
  logic signed [DATA_W-1:0] opa;
  logic signed [COEF_W-1:0] opb;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic                     neg_r;
  logic signed [ACC_W-1:0]  acc_r, addend;
  logic signed [DATA_W-1:0] fin_val;

  always_comb begin
    case (ctrl.a_sel)
      SA_RAW:  opa = raw_r;
      SA_X:    opa = x_r;
      SA_W:    opa = w_r;
      SA_S:    opa = s_r;
      SA_X1:   opa = x1_r;
      SA_X2:   opa = x2_r;
      SA_Y1:   opa = y1_r;
      SA_Y2:   opa = y2_r;
      SA_D1:   opa = d1_r;
      SA_D2:   opa = d2_r;
      default: opa = raw_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.b_sel)
      SB_B0:   opb = cfg.b0;
      SB_B1:   opb = cfg.b1;
      SB_B2:   opb = cfg.b2;
      SB_A1:   opb = cfg.a1;
      SB_A2:   opb = cfg.a2;
      SB_GIN:  opb = cfg.gin;
      SB_GOUT: opb = cfg.gout;
      SB_ONE:  opb = COEF_ONE;
    endcase
  end

  assign prod_nxt = opa * opb;
  assign addend   = neg_r ? -ACC_W'(prod_r) : ACC_W'(prod_r);
  assign fin_val  = scale_back(acc_r);
  assign out_word = fin_val;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    neg_r  <= ctrl.neg;
    if (in_load) begin
      raw_r <= in_sample;
    end
    unique case (ctrl.acc_op)
      ACC_LOAD: acc_r <= addend;
      ACC_ADD:  acc_r <= sat_add(acc_r, addend);
      default:  acc_r <= acc_r;
    endcase
    if (ctrl.fin_en) begin
      unique case (ctrl.fin_dst)
        DST_X:   x_r <= fin_val;
        DST_W:   w_r <= fin_val;
        DST_S:   s_r <= fin_val;
        DST_OUT: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      unique case (ctrl.commit)
        COMMIT_DF1: begin
          x2_r <= x1_r;
          x1_r <= x_r;
          y2_r <= y1_r;
          y1_r <= s_r;
        end
        COMMIT_DF2: begin
          d2_r <= d1_r;
          d1_r <= w_r;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/biquad_iir_filter_top.sv =====
// Biquad IIR section top level: stream ports, configuration port, result register.
// Depends on biq_pkg, biq_cfg, biq_seq and biq_dp.
//
// Second-order IIR section, direct form I or II selected by the form register, with
// Q2.14 coefficients and input/output gains and 16-bit saturated samples. One sample
// occupies the block from acceptance until the result word is loaded, while the single
// shared multiplier and accumulator step through seven or eight products and three
// or four rounding steps. in_tready is low while a sample is in work. A finished word
// waits in the output register while the next sample is already accepted; if it is
// still not taken when the next result is due, the block holds until out_tready.
module biquad_iir_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [biq_pkg::TDATA_W-1:0]   in_tdata,   // sample_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [biq_pkg::TDATA_W-1:0]   out_tdata,  // sample_out
  input  logic                          cfg_wr_en,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [biq_pkg::COEF_W-1:0]    cfg_wdata
);
  import biq_pkg::*;

  cfg_t                     cfg;
  ctrl_t                    ctrl;
  logic                     busy;
  logic                     in_acc;
  logic                     out_load;
  logic signed [DATA_W-1:0] out_word;
  logic                     out_tvalid_r;
  logic [TDATA_W-1:0]       out_tdata_r;

  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = ctrl.fin_en && (ctrl.fin_dst == DST_OUT);

  biq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  biq_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_acc),
    .form        (cfg.form),
    .out_blocked (out_tvalid_r && !out_tready),
    .busy        (busy),
    .ctrl        (ctrl)
  );

  biq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_load   (in_acc),
    .in_sample (in_tdata[DATA_W-1:0]),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .out_word  (out_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= TDATA_W'($unsigned(out_word));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("sequencer not busy after accepting a word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_tvalid_r |-> out_tready)
    else $error("result overwrote a pending output word");

  a_load_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> busy)
    else $error("result loaded while idle");

  a_state_commit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit != COMMIT_NONE) |-> (ctrl.last && out_load))
    else $error("filter state shifted outside the final step");

endmodule
